[hdl/spow_pkg.sv]
// Shared constants, types and neighbor-probe function for the spiral order address walker.
package spow_pkg;

    localparam int MAX_DIM   = 16;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int SIZE_W    = DIM_W + 1;
    localparam int VAL_W     = 9;
    localparam int VIS_N     = MAX_DIM * MAX_DIM;
    localparam int VIS_IDX_W = 2 * DIM_W;
    localparam int HEAD_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = SIZE_W;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 2 * DIM_W + VAL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_CLOCKWISE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_UP       = 3'd6;

    // Heading codes in turn order. Heading 1 and 3 swap east and west when
    // the walker turns counter-clockwise.
    localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_SIDE1 = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_SIDE3 = 2'd3;

    // One step forward and one step back along an axis.
    localparam logic signed [SIZE_W:0] STEP_POS = (SIZE_W+1)'(1);
    localparam logic signed [SIZE_W:0] STEP_NEG = -STEP_POS;

    typedef struct packed {
        logic             off;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
    } t_probe;

    // Clamp a size register to 1..MAX_DIM.
    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_DIM)) begin
            r = SIZE_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Looks one cell ahead in the given heading and flags a step off the grid.
    function automatic t_probe probe_cell(
        input logic [DIM_W-1:0]  col,
        input logic [DIM_W-1:0]  row,
        input logic [HEAD_W-1:0] dir,
        input logic              cw,
        input logic [SIZE_W-1:0] w,
        input logic [SIZE_W-1:0] h
    );
        logic signed [SIZE_W:0] dx;
        logic signed [SIZE_W:0] dy;
        logic signed [SIZE_W:0] sx;
        logic signed [SIZE_W:0] sy;
        t_probe p;
        dx = '0;
        dy = '0;
        case (dir)
            HEAD_NORTH: dy = STEP_NEG;
            HEAD_SIDE1: dx = cw ? STEP_POS : STEP_NEG;
            HEAD_SOUTH: dy = STEP_POS;
            HEAD_SIDE3: dx = cw ? STEP_NEG : STEP_POS;
            default:    dy = '0;
        endcase
        sx = $signed({2'b00, col}) + dx;
        sy = $signed({2'b00, row}) + dy;
        p.off = (sx < 0) || (sx >= $signed({1'b0, w})) ||
                (sy < 0) || (sy >= $signed({1'b0, h}));
        p.col = sx[DIM_W-1:0];
        p.row = sy[DIM_W-1:0];
        return p;
    endfunction

endpackage

[hdl/spiral_order_address_walker_top.sv]
// Spiral order address walker: walks a grid in spiral order, one cell per input transfer.
//
// The slave stream carries one command per transfer: tdata bit 0 set restarts the walk
// (clear the visited map, reload the start corner, heading and count, emit the first
// cell); clear advances to the next cell. Every accepted command produces exactly one
// transfer on the master stream: column, row and sequence value in tdata, tlast on the
// final cell of the spiral, and tuser when the walk is already complete (then all other
// fields are zero).
// The configuration port writes one register per cycle with i_cfg_wr_en; index 0..6
// selects width, height, start column, start row, clockwise turn, start heading and
// count direction; other indexes are ignored. Registers are read live by every command.
// Timing: one command is accepted per cycle while the output register is empty or being
// drained, and its result is valid on the master stream the cycle after acceptance. The
// whole step (a one-bit lookup in the visited map and a few counter updates) sits between
// the walker state and the output register, so the unstalled rate is one cell per cycle.
// Reset: synchronous reset marks the walk complete (the next advance reports idle),
// clears the visited map and the output valid flag, and loads the register defaults.
// Stall: while the receiver holds tready low, the output register keeps its result and
// s_axis_tready stays low until that transfer completes.
module spiral_order_address_walker_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [spow_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [spow_pkg::CFG_DAT_W-1:0]        i_cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: restart; the rest is zero.
    input  logic [spow_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: cell_col[3:0], cell_row[3:0], cell_value[8:0]; zero fill.
    output logic [spow_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast,
    // Fields from bit 0: idle.
    output logic                                  m_axis_tuser
);
    import spow_pkg::*;

    // Configuration registers.
    logic [SIZE_W-1:0] r_grid_width;
    logic [SIZE_W-1:0] r_grid_height;
    logic [DIM_W-1:0]  r_start_col;
    logic [DIM_W-1:0]  r_start_row;
    logic              r_turn_cw;
    logic [HEAD_W-1:0] r_start_heading;
    logic              r_count_up;

    // Walker state.
    logic [DIM_W-1:0]  r_col,     n_col;
    logic [DIM_W-1:0]  r_row,     n_row;
    logic [HEAD_W-1:0] r_heading, n_heading;
    logic [VAL_W-1:0]  r_value,   n_value;
    logic [VAL_W-1:0]  r_left,    n_left;
    logic [VIS_N-1:0]  r_visited, n_visited;

    // Output register.
    logic              r_out_valid;
    logic [DIM_W-1:0]  r_out_col,   n_out_col;
    logic [DIM_W-1:0]  r_out_row,   n_out_row;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    logic              r_out_final, n_out_final;
    logic              r_out_idle,  n_out_idle;

    logic                s_accept;
    logic                restart;
    logic [SIZE_W-1:0]   dim_w;
    logic [SIZE_W-1:0]   dim_h;
    logic [2*SIZE_W-1:0] area_full;
    logic [VAL_W-1:0]    area;
    logic [DIM_W-1:0]    cur_col;
    logic [DIM_W-1:0]    cur_row;
    logic [HEAD_W-1:0]   cur_heading;
    logic [VAL_W-1:0]    cur_value;
    logic [VAL_W-1:0]    cur_left;
    logic [VIS_N-1:0]    cur_visited;
    logic [VAL_W-1:0]    left_dec;
    logic [HEAD_W-1:0]   turned_heading;
    t_probe              probe_fwd;
    t_probe              probe_turn;
    logic                blocked;

    // An output register separates the two sides: a new command is taken
    // whenever the result slot is empty or is being drained this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    assign dim_w     = clamp_dim(r_grid_width);
    assign dim_h     = clamp_dim(r_grid_height);
    assign area_full = dim_w * dim_h;
    assign area      = area_full[VAL_W-1:0];

    always_comb begin
        // A restart reloads the walker before the step is taken.
        if (restart) begin
            cur_col     = ({1'b0, r_start_col} < dim_w) ? r_start_col
                                                          : DIM_W'(dim_w - SIZE_W'(1));
            cur_row     = ({1'b0, r_start_row} < dim_h) ? r_start_row
                                                          : DIM_W'(dim_h - SIZE_W'(1));
            cur_heading = r_start_heading;
            cur_left    = area;
            cur_value   = r_count_up ? VAL_W'(1) : area;
            cur_visited = '0;
        end else begin
            cur_col     = r_col;
            cur_row     = r_row;
            cur_heading = r_heading;
            cur_left    = r_left;
            cur_value   = r_value;
            cur_visited = r_visited;
        end

        n_col       = cur_col;
        n_row       = cur_row;
        n_heading   = cur_heading;
        n_value     = cur_value;
        n_left      = cur_left;
        n_visited   = cur_visited;
        n_out_col   = '0;
        n_out_row   = '0;
        n_out_value = '0;
        n_out_final = 1'b0;
        n_out_idle  = 1'b1;

        left_dec       = cur_left - VAL_W'(1);
        turned_heading = cur_heading + HEAD_W'(1);
        probe_fwd      = probe_cell(cur_col, cur_row, cur_heading, r_turn_cw, dim_w, dim_h);
        probe_turn     = probe_cell(cur_col, cur_row, turned_heading, r_turn_cw,
                                    dim_w, dim_h);
        blocked        = 1'b0;

        if (cur_left != '0) begin
            n_out_col   = cur_col;
            n_out_row   = cur_row;
            n_out_value = cur_value;
            n_out_idle  = 1'b0;
            n_visited[{cur_row, cur_col}] = 1'b1;
            n_left  = left_dec;
            n_value = r_count_up ? cur_value + VAL_W'(1) : cur_value - VAL_W'(1);

            if (left_dec == '0) begin
                n_out_final = 1'b1;
            end else begin
                // The visited bit is only looked at when the cell ahead is on
                // the grid. After a turn the move is not checked again.
                blocked = probe_fwd.off || n_visited[{probe_fwd.row, probe_fwd.col}];
                if (blocked) begin
                    n_heading = turned_heading;
                    if (probe_turn.off) begin
                        n_left      = '0;
                        n_out_final = 1'b1;
                    end else begin
                        n_col = probe_turn.col;
                        n_row = probe_turn.row;
                    end
                end else begin
                    n_col = probe_fwd.col;
                    n_row = probe_fwd.row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width    <= SIZE_W'(MAX_DIM);
            r_grid_height   <= SIZE_W'(MAX_DIM);
            r_start_col     <= '0;
            r_start_row     <= '0;
            r_turn_cw       <= 1'b1;
            r_start_heading <= HEAD_SIDE1;
            r_count_up      <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_GRID_WIDTH:     r_grid_width    <= i_cfg_wdata;
                CFG_GRID_HEIGHT:    r_grid_height   <= i_cfg_wdata;
                CFG_START_COL:      r_start_col     <= i_cfg_wdata[DIM_W-1:0];
                CFG_START_ROW:      r_start_row     <= i_cfg_wdata[DIM_W-1:0];
                CFG_TURN_CLOCKWISE: r_turn_cw       <= i_cfg_wdata[0];
                CFG_START_HEADING:  r_start_heading <= i_cfg_wdata[HEAD_W-1:0];
                CFG_COUNT_UP:       r_count_up      <= i_cfg_wdata[0];
                default:            r_count_up      <= r_count_up;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_heading <= HEAD_NORTH;
            r_value   <= '0;
            r_left    <= '0;
            r_visited <= '0;
        end else if (s_accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_heading <= n_heading;
            r_value   <= n_value;
            r_left    <= n_left;
            r_visited <= n_visited;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_out_value <= n_out_value;
            r_out_final <= n_out_final;
            r_out_idle  <= n_out_idle;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_value, r_out_row, r_out_col});
    assign m_axis_tlast  = r_out_final;
    assign m_axis_tuser  = r_out_idle;

    // An advance on a finished walk must report idle.
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !restart && (r_left == '0)) |=> (m_axis_tvalid && m_axis_tuser))
        else $error("advance on a finished walk did not report idle");

    // A final cell leaves the walk complete.
    a_final_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && n_out_final) |=> (r_left == '0))
        else $error("walk continues after the final cell");

    // A restart leaves exactly the first cell marked as visited.
    a_restart_marks_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && restart) |=> ($countones(r_visited) == 1))
        else $error("visited map not cleared on restart");

endmodule

[tb/spiral_order_address_walker_top_test.sv]
// Self-checking testbench for the spiral order address walker: table-driven and random command streams.
module spiral_order_address_walker_top_test;

    import spow_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET  = 1500;
    localparam int MAX_WAIT     = 14;
    // The slowest legal run is roughly 2000 commands with random gaps on both sides, plus
    // a few hundred register writes; the limit leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 200;

    // One expected master-side transfer, split into its fields.
    typedef struct packed {
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic [VAL_W-1:0] value;
        logic             last_cell;
        logic             idle;
    } t_cell;

    // One line of the directed table: either a register write or a command.
    // When "typed" is set the transfer in the row is the expectation; otherwise
    // the walk predictor supplies it.
    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DAT_W-1:0] reg_val;
        logic                 restart;
        logic                 typed;
        t_cell                want;
    } t_plan_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr    = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    // Live copy of the configuration registers, as the block sees them.
    logic [SIZE_W-1:0] reg_width;
    logic [SIZE_W-1:0] reg_height;
    logic [DIM_W-1:0]  reg_start_col;
    logic [DIM_W-1:0]  reg_start_row;
    logic              reg_cw;
    logic [HEAD_W-1:0] reg_head;
    logic              reg_up;

    // Predicted walker state.
    logic [DIM_W-1:0]  walk_col;
    logic [DIM_W-1:0]  walk_row;
    logic [HEAD_W-1:0] walk_dir;
    logic [VAL_W-1:0]  walk_seq;
    int                walk_left;
    bit                visited [VIS_N];

    t_cell cells_due [$];
    int    items_sent  = 0;
    int    error_count = 0;
    int    cycle_count = 0;
    // When set, both sides drop their random gaps so that back-to-back
    // transfers are exercised in stretches.
    bit    rush = 1'b0;

    spiral_order_address_walker_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // Fields from bit 0: restart; the rest is zero.
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // Fields from bit 0: cell_col[3:0], cell_row[3:0], cell_value[8:0]; zero fill.
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        // Fields from bit 0: idle.
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** spiral_order_address_walker_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Walk predictor
    // ------------------------------------------------------------------

    // Size registers are clamped to 1..MAX_DIM before use.
    function automatic int clamp_size(input logic [SIZE_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // East and west swap places between heading 1 and 3 with the turn sense.
    function automatic void heading_delta(input logic [HEAD_W-1:0] d, input logic cw,
                                          output int dx, output int dy);
        dx = 0;
        dy = 0;
        case (d)
            HEAD_NORTH: dy = -1;
            HEAD_SIDE1: dx = cw ? 1 : -1;
            HEAD_SOUTH: dy = 1;
            default:    dx = cw ? -1 : 1;
        endcase
    endfunction

    function automatic bit outside(input int x, input int y, input int w, input int h);
        return (x < 0) || (y < 0) || (x >= w) || (y >= h);
    endfunction

    // Advances the predicted walker by one accepted command and returns the
    // transfer that the block must produce for it.
    function automatic t_cell spiral_step(input logic restart);
        int    w;
        int    h;
        int    nx;
        int    ny;
        int    dx;
        int    dy;
        t_cell c;
        w = clamp_size(reg_width);
        h = clamp_size(reg_height);
        c = '0;
        if (restart) begin
            foreach (visited[i]) visited[i] = 1'b0;
            // A start outside the grid saturates to the last column or row.
            walk_col  = (reg_start_col < w) ? reg_start_col : DIM_W'(w - 1);
            walk_row  = (reg_start_row < h) ? reg_start_row : DIM_W'(h - 1);
            walk_dir  = reg_head;
            walk_left = w * h;
            walk_seq  = reg_up ? VAL_W'(1) : VAL_W'(w * h);
        end
        if (walk_left == 0) begin
            c.idle = 1'b1;
            return c;
        end
        c.col   = walk_col;
        c.row   = walk_row;
        c.value = walk_seq;
        visited[{walk_row, walk_col}] = 1'b1;
        walk_left--;
        walk_seq = reg_up ? walk_seq + 1'b1 : walk_seq - 1'b1;
        if (walk_left == 0) begin
            c.last_cell = 1'b1;
        end else begin
            heading_delta(walk_dir, reg_cw, dx, dy);
            nx = int'(walk_col) + dx;
            ny = int'(walk_row) + dy;
            // Turn once on a wall or a visited cell; the move after the turn
            // is taken without looking at the visited map.
            if (outside(nx, ny, w, h) || visited[ny * MAX_DIM + nx]) begin
                walk_dir = walk_dir + 1'b1;
                heading_delta(walk_dir, reg_cw, dx, dy);
                nx = int'(walk_col) + dx;
                ny = int'(walk_row) + dy;
            end
            // A move that still leaves the grid ends the walk early.
            if (outside(nx, ny, w, h)) begin
                walk_left   = 0;
                c.last_cell = 1'b1;
            end else begin
                walk_col = DIM_W'(nx);
                walk_row = DIM_W'(ny);
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Drivers and checker
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("ERROR cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        end
    endtask

    // Drops tvalid after the last accepted command and holds the sender until
    // every predicted transfer has come out of the block.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
    endtask

    // Register writes only happen while nothing is in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            CFG_GRID_WIDTH:     reg_width     = val;
            CFG_GRID_HEIGHT:    reg_height    = val;
            CFG_START_COL:      reg_start_col = val[DIM_W-1:0];
            CFG_START_ROW:      reg_start_row = val[DIM_W-1:0];
            CFG_TURN_CLOCKWISE: reg_cw        = val[0];
            CFG_START_HEADING:  reg_head      = val[HEAD_W-1:0];
            CFG_COUNT_UP:       reg_up        = val[0];
            default:            ;
        endcase
    endtask

    // Sends one command. tvalid stays high across back-to-back commands and
    // the expectation is queued at the edge where the transfer completes.
    task automatic send_cmd(input logic restart, input logic typed, input t_cell typed_cell);
        int    gap;
        t_cell c;
        gap = rush ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_TDATA_W'(restart);
        do @(posedge i_clk); while (!s_axis_tready);
        c = spiral_step(restart);
        cells_due.push_back(typed ? typed_cell : c);
        items_sent++;
    endtask

    task automatic check_cell();
        t_cell want;
        if (cells_due.size() == 0) begin
            flag_mismatch("transfer with nothing expected, tdata", int'(m_axis_tdata), 0);
            return;
        end
        want = cells_due.pop_front();
        if (m_axis_tdata[3:0] !== want.col)
            flag_mismatch("cell_col", int'(m_axis_tdata[3:0]), int'(want.col));
        if (m_axis_tdata[7:4] !== want.row)
            flag_mismatch("cell_row", int'(m_axis_tdata[7:4]), int'(want.row));
        if (m_axis_tdata[16:8] !== want.value)
            flag_mismatch("cell_value", int'(m_axis_tdata[16:8]), int'(want.value));
        if (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
            flag_mismatch("tdata fill", int'(m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W]), 0);
        if (m_axis_tlast !== want.last_cell)
            flag_mismatch("final_cell", int'(m_axis_tlast), int'(want.last_cell));
        if (m_axis_tuser !== want.idle)
            flag_mismatch("idle", int'(m_axis_tuser), int'(want.idle));
    endtask

    // Receiver: random stalls on tready, every transfer checked at the edge
    // where it completes.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = rush ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            check_cell();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_plan_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] val);
        t_plan_row r;
        r          = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    function automatic t_plan_row cmd_row(input logic restart);
        t_plan_row r;
        r         = '0;
        r.restart = restart;
        return r;
    endfunction

    function automatic t_plan_row cell_row(input logic restart, input int col, input int row,
                                           input int value, input logic last_cell);
        t_plan_row r;
        r                = '0;
        r.restart        = restart;
        r.typed          = 1'b1;
        r.want.col       = DIM_W'(col);
        r.want.row       = DIM_W'(row);
        r.want.value     = VAL_W'(value);
        r.want.last_cell = last_cell;
        return r;
    endfunction

    // An advance after the walk has finished reports idle with all fields zero.
    function automatic t_plan_row idle_row();
        t_plan_row r;
        r           = '0;
        r.typed     = 1'b1;
        r.want.idle = 1'b1;
        return r;
    endfunction

    // Mostly small grids, with full size and the clamped values mixed in.
    function automatic logic [CFG_DAT_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) return CFG_DAT_W'($urandom_range(1, 5));
        if (r < 15) return CFG_DAT_W'($urandom_range(6, 15));
        if (r < 17) return CFG_DAT_W'(MAX_DIM);
        if (r == 17) return '0;
        return CFG_DAT_W'($urandom_range(MAX_DIM + 1, 31));
    endfunction

    // The heading that makes a full spiral from a given corner.
    function automatic logic [HEAD_W-1:0] spiral_heading(input logic cw, input logic top,
                                                         input logic left);
        case ({cw, top, left})
            3'b111:  return HEAD_SIDE1;
            3'b110:  return HEAD_SOUTH;
            3'b100:  return HEAD_SIDE3;
            3'b101:  return HEAD_NORTH;
            3'b011:  return HEAD_SOUTH;
            3'b010:  return HEAD_SIDE1;
            3'b000:  return HEAD_NORTH;
            default: return HEAD_SIDE3;
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
        case (idx)
            CFG_GRID_WIDTH, CFG_GRID_HEIGHT: return pick_size();
            CFG_START_COL, CFG_START_ROW:    return CFG_DAT_W'($urandom_range(0, MAX_DIM - 1));
            CFG_START_HEADING:               return CFG_DAT_W'($urandom_range(0, 3));
            default:                         return CFG_DAT_W'($urandom_range(0, 1));
        endcase
    endfunction

    // Writes all seven registers for a new walk. Most walks start at a corner
    // with the heading that gives a real spiral; the rest start anywhere or
    // head the wrong way, which ends the walk early or makes it revisit cells.
    task automatic configure_walk(output int cells);
        logic [CFG_DAT_W-1:0] wv;
        logic [CFG_DAT_W-1:0] hv;
        int                   wc;
        int                   hc;
        logic                 top;
        logic                 left;
        logic                 cw;
        logic [HEAD_W-1:0]    head;
        wv   = pick_size();
        hv   = pick_size();
        wc   = clamp_size(wv);
        hc   = clamp_size(hv);
        top  = 1'($urandom_range(0, 1));
        left = 1'($urandom_range(0, 1));
        cw   = 1'($urandom_range(0, 1));
        head = ($urandom_range(0, 3) == 0) ? HEAD_W'($urandom_range(0, 3))
                                           : spiral_heading(cw, top, left);
        write_reg(CFG_GRID_WIDTH, wv);
        write_reg(CFG_GRID_HEIGHT, hv);
        write_reg(CFG_START_COL, ($urandom_range(0, 7) == 0) ? CFG_DAT_W'($urandom_range(0, 15))
                                                             : CFG_DAT_W'(left ? 0 : wc - 1));
        write_reg(CFG_START_ROW, ($urandom_range(0, 7) == 0) ? CFG_DAT_W'($urandom_range(0, 15))
                                                             : CFG_DAT_W'(top ? 0 : hc - 1));
        write_reg(CFG_TURN_CLOCKWISE, CFG_DAT_W'(cw));
        write_reg(CFG_START_HEADING, CFG_DAT_W'(head));
        write_reg(CFG_COUNT_UP, CFG_DAT_W'($urandom_range(0, 1)));
        cells = wc * hc;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_plan_row plan [$];
        int        kind;
        int        cells;
        int        span;

        reg_width     = SIZE_W'(MAX_DIM);
        reg_height    = SIZE_W'(MAX_DIM);
        reg_start_col = '0;
        reg_start_row = '0;
        reg_cw        = 1'b1;
        reg_head      = HEAD_SIDE1;
        reg_up        = 1'b1;
        walk_col      = '0;
        walk_row      = '0;
        walk_dir      = HEAD_NORTH;
        walk_seq      = '0;
        walk_left     = 0;
        foreach (visited[i]) visited[i] = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        plan = '{
            // Out of reset the walk counts as complete, so an advance is idle.
            idle_row(),
            // A 2x2 clockwise walk from the top-left corner heading east.
            reg_row(CFG_GRID_WIDTH, 5'd2),
            reg_row(CFG_GRID_HEIGHT, 5'd2),
            cell_row(1'b1, 0, 0, 1, 1'b0),
            cell_row(1'b0, 1, 0, 2, 1'b0),
            cell_row(1'b0, 1, 1, 3, 1'b0),
            cell_row(1'b0, 0, 1, 4, 1'b1),
            idle_row(),
            // Sizes out of range clamp to a 1x16 column; counting down from 16.
            reg_row(CFG_GRID_WIDTH, 5'd0),
            reg_row(CFG_GRID_HEIGHT, 5'd31),
            reg_row(CFG_COUNT_UP, 5'd0),
            cell_row(1'b1, 0, 0, 16, 1'b0),
            cmd_row(1'b0),
            cmd_row(1'b0),
            // A start past the grid saturates to (2,0) of a 3x1 grid; heading
            // east, the turn south also leaves the grid and the walk ends there.
            reg_row(CFG_GRID_WIDTH, 5'd3),
            reg_row(CFG_GRID_HEIGHT, 5'd1),
            reg_row(CFG_START_COL, 5'd15),
            reg_row(CFG_START_ROW, 5'd15),
            cell_row(1'b1, 2, 0, 3, 1'b1),
            idle_row(),
            // Center start of a 3x3 grid, counter-clockwise, heading north:
            // not a corner, so the walk winds outward from the center.
            reg_row(CFG_GRID_WIDTH, 5'd3),
            reg_row(CFG_GRID_HEIGHT, 5'd3),
            reg_row(CFG_START_COL, 5'd1),
            reg_row(CFG_START_ROW, 5'd1),
            reg_row(CFG_START_HEADING, CFG_DAT_W'(HEAD_NORTH)),
            reg_row(CFG_TURN_CLOCKWISE, 5'd0),
            reg_row(CFG_COUNT_UP, 5'd1),
            cmd_row(1'b1),
            cmd_row(1'b0),
            cmd_row(1'b0),
            cmd_row(1'b0),
            cmd_row(1'b0),
            // Widen the grid with the walk still running; the new bound
            // applies from the next command on.
            reg_row(CFG_GRID_WIDTH, 5'd16),
            cmd_row(1'b0),
            cmd_row(1'b0),
            cmd_row(1'b0)
        };

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_cmd(plan[i].restart, plan[i].typed, plan[i].want);
            end
        end

        // One full 16x16 spiral, counter-clockwise from the bottom-right
        // corner and counting down, so the largest grid and value are covered.
        wait_idle();
        write_reg(CFG_GRID_WIDTH, CFG_DAT_W'(MAX_DIM));
        write_reg(CFG_GRID_HEIGHT, CFG_DAT_W'(MAX_DIM));
        write_reg(CFG_START_COL, CFG_DAT_W'(MAX_DIM - 1));
        write_reg(CFG_START_ROW, CFG_DAT_W'(MAX_DIM - 1));
        write_reg(CFG_TURN_CLOCKWISE, 5'd0);
        write_reg(CFG_START_HEADING, CFG_DAT_W'(HEAD_NORTH));
        write_reg(CFG_COUNT_UP, 5'd0);
        send_cmd(1'b1, 1'b0, '0);
        repeat (MAX_DIM * MAX_DIM + 1) send_cmd(1'b0, 1'b0, '0);

        // Random phases. Each one begins with the block drained, which is also
        // where the sender holds off until every result is back.
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            rush = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // A full walk, now and then cut short, with a few idle advances.
                configure_walk(cells);
                span = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cells) : cells;
                send_cmd(1'b1, 1'b0, '0);
                repeat (span - 1 + $urandom_range(0, 2)) send_cmd(1'b0, 1'b0, '0);
            end else if (kind == 7) begin
                // Registers change in the middle of a walk.
                configure_walk(cells);
                send_cmd(1'b1, 1'b0, '0);
                repeat ($urandom_range(0, cells)) send_cmd(1'b0, 1'b0, '0);
                wait_idle();
                repeat ($urandom_range(1, 2)) begin
                    kind = $urandom_range(0, 6);
                    write_reg(CFG_IDX_W'(kind), pick_reg_value(CFG_IDX_W'(kind)));
                end
                repeat ($urandom_range(1, cells + 2)) send_cmd(1'b0, 1'b0, '0);
            end else begin
                // Noise: restarts scattered through the command stream.
                repeat ($urandom_range(10, 40))
                    send_cmd($urandom_range(0, 7) == 0, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** spiral_order_address_walker_top: PASSED **");
        end else begin
            $display("** spiral_order_address_walker_top: FAILED **");
        end
        $finish;
    end

endmodule
